@@ design/dbfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfc_pkg: shared types and constants for the detection box filter
// Field widths, register indexes, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dbfc_pkg;

    localparam int LABEL_W    = 8;
    localparam int SCORE_W    = 17;
    localparam int NORM_W     = 18;
    localparam int PIX_W      = 14;
    localparam int EDGE_W     = 15;
    localparam int SIZE_W     = 16;
    localparam int IDX_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_BOXES_DEF       = 256;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int MIN_CROP  = 16;
    localparam int MIN_OUT   = 32;
    localparam int OUT_SHIFT = 5;

    localparam logic [LABEL_W-1:0] FACE_LABEL = 8'd1;

    localparam int DIV_NUM_W = EDGE_W + OUT_SHIFT;
    localparam int DIV_DEN_W = EDGE_W;
    localparam int DIV_STEPS = DIV_NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H     = 2'd2;

    localparam logic [SCORE_W-1:0] THR_RESET   = 17'd26214;
    localparam logic [PIX_W-1:0]   IMG_W_RESET = 14'd1920;
    localparam logic [PIX_W-1:0]   IMG_H_RESET = 14'd1080;

    localparam logic [1:0] COORD_LEFT   = 2'd0;
    localparam logic [1:0] COORD_TOP    = 2'd1;
    localparam logic [1:0] COORD_RIGHT  = 2'd2;
    localparam logic [1:0] COORD_BOTTOM = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       align;
        logic       div_start;
        logic       div_step;
        logic       div_commit;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic keep;
        logic need_scale;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

@@ design/dbfc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfc_ctrl: sequencer for the box filter
// Steps one item through scaling, size check, alignment, divide and output.
// ----------------------------------------------------------------------------
module dbfc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dbfc_pkg::t_status  i_status,
    output dbfc_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_SCALE,
        S_DIV,
        S_COMMIT,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [dbfc_pkg::CNT_W-1:0]    r_cnt;

    localparam logic [dbfc_pkg::CNT_W-1:0] MUL_LAST =
        dbfc_pkg::CNT_W'(dbfc_pkg::MUL_STEPS - 1);
    localparam logic [dbfc_pkg::CNT_W-1:0] DIV_LAST =
        dbfc_pkg::CNT_W'(dbfc_pkg::DIV_STEPS - 1);

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = r_cnt[1:0];
        unique case (r_state)
            S_IDLE:   o_cmd.load       = i_valid;
            S_MUL:    o_cmd.mul_en     = 1'b1;
            S_CHECK:  o_cmd.align      = i_status.keep;
            S_SCALE:  o_cmd.div_start  = i_status.need_scale;
            S_DIV:    o_cmd.div_step   = 1'b1;
            S_COMMIT: o_cmd.div_commit = 1'b1;
            S_OUT:    o_cmd.out_load   = i_status.out_free;
            default:  o_cmd            = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_valid) r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHECK: r_state <= i_status.keep ? S_SCALE : S_IDLE;
                S_SCALE: begin
                    r_cnt   <= '0;
                    r_state <= i_status.need_scale ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_COMMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_COMMIT: r_state <= S_OUT;
                S_OUT: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/dbfc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfc_dp: datapath for the box filter
// Config registers, shared coordinate multiplier, edge alignment, serial
// restoring divider, face counter and output register.
// ----------------------------------------------------------------------------
module dbfc_dp #(
    parameter int MAX_BOXES       = dbfc_pkg::MAX_BOXES_DEF,
    parameter int COORD_FRAC_BITS = dbfc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dbfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dbfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_first_of_frame,
    input  logic [dbfc_pkg::LABEL_W-1:0]        i_label,
    input  logic [dbfc_pkg::SCORE_W-1:0]        i_score,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_left_norm,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_top_norm,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_right_norm,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_bottom_norm,
    input  dbfc_pkg::t_cmd                      i_cmd,
    output dbfc_pkg::t_status                   o_status,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [dbfc_pkg::IDX_W-1:0]          o_face_index,
    output logic [dbfc_pkg::SCORE_W-1:0]        o_face_score,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_left,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_right,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_top,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_bottom,
    output logic [dbfc_pkg::SIZE_W-1:0]         o_out_width,
    output logic [dbfc_pkg::SIZE_W-1:0]         o_out_height
);

    localparam int PIX_W  = dbfc_pkg::PIX_W;
    localparam int EDGE_W = dbfc_pkg::EDGE_W;
    localparam int SIZE_W = dbfc_pkg::SIZE_W;
    localparam int NORM_W = dbfc_pkg::NORM_W;
    localparam int NUM_W  = dbfc_pkg::DIV_NUM_W;
    localparam int DEN_W  = dbfc_pkg::DIV_DEN_W;
    localparam int CAP    = (MAX_BOXES < 511) ? MAX_BOXES : 511;
    localparam int CW     = (COORD_FRAC_BITS + 1 > NORM_W) ? COORD_FRAC_BITS + 1 : NORM_W;
    localparam int PW     = CW + PIX_W;

    localparam logic [dbfc_pkg::IDX_W-1:0] FACE_CAP = dbfc_pkg::IDX_W'(CAP);
    localparam logic [CW-1:0]              ONE      = CW'(1) << COORD_FRAC_BITS;
    localparam logic [EDGE_W-1:0]          CROP_MIN = EDGE_W'(dbfc_pkg::MIN_CROP);
    localparam logic [SIZE_W-1:0]          OUT_MIN  = SIZE_W'(dbfc_pkg::MIN_OUT);

    // configuration
    logic [dbfc_pkg::SCORE_W-1:0] r_thr;
    logic [PIX_W-1:0]             r_img_w;
    logic [PIX_W-1:0]             r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= dbfc_pkg::THR_RESET;
            r_img_w <= dbfc_pkg::IMG_W_RESET;
            r_img_h <= dbfc_pkg::IMG_H_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dbfc_pkg::CFG_SCORE_THR: r_thr   <= i_cfg_data;
                dbfc_pkg::CFG_IMG_W:     r_img_w <= i_cfg_data[PIX_W-1:0];
                dbfc_pkg::CFG_IMG_H:     r_img_h <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [dbfc_pkg::LABEL_W-1:0] r_label;
    logic [dbfc_pkg::SCORE_W-1:0] r_score;
    logic [NORM_W-1:0]            r_norm [4];
    logic [PIX_W-1:0]             r_pix  [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_label                        <= i_label;
            r_score                        <= i_score;
            r_norm[dbfc_pkg::COORD_LEFT]   <= i_left_norm;
            r_norm[dbfc_pkg::COORD_TOP]    <= i_top_norm;
            r_norm[dbfc_pkg::COORD_RIGHT]  <= i_right_norm;
            r_norm[dbfc_pkg::COORD_BOTTOM] <= i_bottom_norm;
        end
    end

    // clamp to 0..1.0 and scale to pixels, one corner per cycle
    logic [NORM_W-1:0] mul_v;
    logic [CW-1:0]     mul_ext;
    logic [CW-1:0]     mul_c;
    logic [PIX_W-1:0]  mul_size;
    logic [PW-1:0]     mul_prod;
    logic [PW-1:0]     mul_shr;

    always_comb begin
        mul_v    = r_norm[i_cmd.mul_sel];
        mul_ext  = CW'(mul_v[NORM_W-2:0]);
        mul_c    = mul_v[NORM_W-1] ? '0 : ((mul_ext > ONE) ? ONE : mul_ext);
        mul_size = i_cmd.mul_sel[0] ? r_img_h : r_img_w;
        mul_prod = PW'(mul_c) * PW'(mul_size);
        mul_shr  = mul_prod >> COORD_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_pix[i_cmd.mul_sel] <= mul_shr[PIX_W-1:0];
    end

    // size check and alignment
    logic [PIX_W-1:0]  lx, ty, rx, by;
    logic              pass, size_ok;
    logic [EDGE_W-1:0] hmin_c, vmin_c, w_c, h_c;
    logic [PIX_W-1:0]  hmax_c, vmax_c;

    always_comb begin
        lx      = r_pix[dbfc_pkg::COORD_LEFT];
        ty      = r_pix[dbfc_pkg::COORD_TOP];
        rx      = r_pix[dbfc_pkg::COORD_RIGHT];
        by      = r_pix[dbfc_pkg::COORD_BOTTOM];
        pass    = (r_score >= r_thr) && (r_label == dbfc_pkg::FACE_LABEL);
        size_ok = (EDGE_W'(rx) >= EDGE_W'(lx) + CROP_MIN)
               && (EDGE_W'(by) >= EDGE_W'(ty) + CROP_MIN);
        hmin_c  = EDGE_W'(lx) + EDGE_W'(lx[0]);
        vmin_c  = EDGE_W'(ty) + EDGE_W'(ty[0]);
        hmax_c  = rx[0] ? rx : rx - 1'b1;
        vmax_c  = by[0] ? by : by - 1'b1;
        w_c     = EDGE_W'(hmax_c) - hmin_c + 1'b1;
        h_c     = EDGE_W'(vmax_c) - vmin_c + 1'b1;
    end

    logic [EDGE_W-1:0] r_hmin, r_vmin;
    logic [PIX_W-1:0]  r_hmax, r_vmax;
    logic [SIZE_W-1:0] r_w, r_h;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;

    logic              w_lt_h;
    logic [SIZE_W-1:0] big, small_side;
    logic [DEN_W:0]    rem_sh, rem_diff;
    logic              q_bit;

    always_comb begin
        w_lt_h     = r_w < r_h;
        big        = w_lt_h ? r_h : r_w;
        small_side = w_lt_h ? r_w : r_h;
        rem_sh     = {r_rem, r_num[NUM_W-1]};
        rem_diff   = rem_sh - {1'b0, r_den};
        q_bit      = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.align) begin
            r_hmin <= hmin_c;
            r_vmin <= vmin_c;
            r_hmax <= hmax_c;
            r_vmax <= vmax_c;
            r_w    <= SIZE_W'(w_c);
            r_h    <= SIZE_W'(h_c);
        end else if (i_cmd.div_commit) begin
            if (w_lt_h) begin
                r_w <= OUT_MIN;
                r_h <= r_num[SIZE_W-1:0];
            end else begin
                r_w <= r_num[SIZE_W-1:0];
                r_h <= OUT_MIN;
            end
        end
        if (i_cmd.div_start) begin
            r_num <= NUM_W'(big[EDGE_W-1:0]) << dbfc_pkg::OUT_SHIFT;
            r_den <= small_side[DEN_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], q_bit};
        end
    end

    // face numbering and output register
    logic [dbfc_pkg::IDX_W-1:0] r_faces;
    logic [dbfc_pkg::IDX_W-1:0] n_faces;
    logic                       r_o_valid;

    assign n_faces = (r_faces < FACE_CAP) ? r_faces + 1'b1 : r_faces;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faces   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_first_of_frame) r_faces <= '0;
            else if (i_cmd.out_load)            r_faces <= n_faces;
            if (i_cmd.out_load)                 r_o_valid <= 1'b1;
            else if (!i_stall)                  r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_face_index  <= n_faces;
            o_face_score  <= r_score;
            o_crop_left   <= r_hmin[PIX_W-1:0];
            o_crop_right  <= r_hmax;
            o_crop_top    <= r_vmin[PIX_W-1:0];
            o_crop_bottom <= r_vmax;
            o_out_width   <= r_w + SIZE_W'(r_w[0]);
            o_out_height  <= r_h + SIZE_W'(r_h[0]);
        end
    end

    assign o_valid             = r_o_valid;
    assign o_status.keep       = pass && size_ok;
    assign o_status.need_scale = (r_w < OUT_MIN) || (r_h < OUT_MIN);
    assign o_status.out_free   = !r_o_valid || !i_stall;

endmodule
`default_nettype wire

@@ design/detection_box_filter_and_crop.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detection_box_filter_and_crop: face box filter and crop planner
// Filters detector records by score and label, scales corners to pixels,
// aligns crop edges, upscales small boxes and numbers faces per frame.
// ----------------------------------------------------------------------------
// One item at a time. The four corners share one multiplier, and a kept
// record whose box needs the minimum-size upscale runs a 20-step serial
// divider. A finished result sits in the output register, so the next item
// is accepted while it waits to be taken. The user must write registers
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module detection_box_filter_and_crop #(
    parameter int MAX_BOXES       = dbfc_pkg::MAX_BOXES_DEF,
    parameter int COORD_FRAC_BITS = dbfc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dbfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dbfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_first_of_frame,
    input  logic [dbfc_pkg::LABEL_W-1:0]        i_label,
    input  logic [dbfc_pkg::SCORE_W-1:0]        i_score,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_left_norm,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_top_norm,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_right_norm,
    input  logic signed [dbfc_pkg::NORM_W-1:0]  i_bottom_norm,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dbfc_pkg::IDX_W-1:0]          o_face_index,
    output logic [dbfc_pkg::SCORE_W-1:0]        o_face_score,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_left,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_right,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_top,
    output logic [dbfc_pkg::PIX_W-1:0]          o_crop_bottom,
    output logic [dbfc_pkg::SIZE_W-1:0]         o_out_width,
    output logic [dbfc_pkg::SIZE_W-1:0]         o_out_height
);

    dbfc_pkg::t_cmd    cmd;
    dbfc_pkg::t_status status;

    dbfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dbfc_dp #(
        .MAX_BOXES       (MAX_BOXES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_first_of_frame (i_first_of_frame),
        .i_label          (i_label),
        .i_score          (i_score),
        .i_left_norm      (i_left_norm),
        .i_top_norm       (i_top_norm),
        .i_right_norm     (i_right_norm),
        .i_bottom_norm    (i_bottom_norm),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_face_index     (o_face_index),
        .o_face_score     (o_face_score),
        .o_crop_left      (o_crop_left),
        .o_crop_right     (o_crop_right),
        .o_crop_top       (o_crop_top),
        .o_crop_bottom    (o_crop_bottom),
        .o_out_width      (o_out_width),
        .o_out_height     (o_out_height)
    );

endmodule
`default_nettype wire
